### rtl/sqd_pkg.sv
package sqd_pkg;

  // Item kinds on the input channel
  localparam logic MODE_HDR  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // Float constants
  localparam logic [31:0] F32_POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;

  // Sequencer steps: four scale products, two weights, two accumulates
  typedef enum logic [2:0] {
    OP_D1 = 3'd0,
    OP_M1 = 3'd1,
    OP_D2 = 3'd2,
    OP_M2 = 3'd3,
    OP_VL = 3'd4,
    OP_VH = 3'd5,
    OP_AL = 3'd6,
    OP_AH = 3'd7
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load_hdr;
    logic load_item;
    logic start;
    logic write_res;
    logic emit;
    op_t  op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fma_done;
    logic out_free;
    logic row_end;
  } sts_t;

endpackage

### rtl/sqd_if.sv
// Input beat: header or packed data byte
interface sqd_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] block_scale_half;
  logic [15:0] block_min_half;
  logic [63:0] packed_scales_low;
  logic [31:0] packed_scales_high;
  logic [7:0]  quant_byte;
  logic [31:0] act_for_low;
  logic [31:0] act_for_high;
  logic        row_end;

  modport source (
    output valid, mode, block_scale_half, block_min_half, packed_scales_low,
           packed_scales_high, quant_byte, act_for_low, act_for_high, row_end,
    input  ready
  );
  modport sink (
    input  valid, mode, block_scale_half, block_min_half, packed_scales_low,
           packed_scales_high, quant_byte, act_for_low, act_for_high, row_end,
    output ready
  );
endinterface

// Result beat: row dot product
interface sqd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_value;

  modport source (output valid, dot_value, input ready);
  modport sink (input valid, dot_value, output ready);
endinterface

### rtl/super_block_q4_dot_product.sv
// Channel  Dir  Beat contents
// in_bus   in   header (d, dmin, 12 scale bytes) or data byte with two activations
// out_bus  out  float dot product of one row, once per row end
//
// A header beat is stored as it is accepted. A data beat runs eight passes through the
// shared six-stage FMA unit, one at a time, after the accept cycle; a row end adds the
// emit state, held while the output slot is still full.
// All floating-point products and sums pass through the FMA unit.
// rst_n is synchronous, active low; it clears the accumulator, position, block scale and block min.
// A result waiting in the output slot stalls the input only once the next row end is done.
module super_block_q4_dot_product (
  input  logic      clk,
  input  logic      rst_n,
  sqd_in_if.sink    in_bus,
  sqd_out_if.source out_bus
);

  sqd_pkg::cmd_t cmd;
  sqd_pkg::sts_t sts;

  sqd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_mode  (in_bus.mode),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sqd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .block_scale_half   (in_bus.block_scale_half),
    .block_min_half     (in_bus.block_min_half),
    .packed_scales_low  (in_bus.packed_scales_low),
    .packed_scales_high (in_bus.packed_scales_high),
    .quant_byte         (in_bus.quant_byte),
    .act_for_low        (in_bus.act_for_low),
    .act_for_high       (in_bus.act_for_high),
    .row_end            (in_bus.row_end),
    .out_ready          (out_bus.ready),
    .out_valid          (out_bus.valid),
    .dot_value          (out_bus.dot_value)
  );

`ifndef ASSERT_OFF
  // a data beat starts the FMA sequence in the next cycle
  a_data_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.mode == sqd_pkg::MODE_DATA) |=> cmd.start)
    else $error("data beat did not start FMA");

  // a result is loaded only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_bus.valid || out_bus.ready))
    else $error("result overwrote pending output");

  // no beat is taken while an FMA pass completes
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fma_done |-> !in_bus.ready)
    else $error("input accepted during FMA sequence");
`endif

endmodule

### rtl/sqd_fma.sv
// Single-precision fused multiply-add, six stages; the controller issues one operation at a time.
// result = round_nearest_even(a * b + c); any NaN result is the canonical quiet NaN.
module sqd_fma (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  input  logic [31:0] op_c,
  output logic        done,
  output logic [31:0] result
);

  localparam logic [33:0] EXP_OVF = 34'h0_7F80_0000;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [6:0] lzc77(input logic [76:0] v);
    logic [6:0] n;
    n = 7'd77;
    for (int i = 0; i < 77; i++) begin
      if (v[i]) n = 7'(76 - i);
    end
    return n;
  endfunction

  logic [5:0] v_r;

  // stage 1: unpack, specials, significand product
  logic [47:0]        s1_mp_r;
  logic [9:0]         s1_eab_r;
  logic               s1_sp_r;
  logic [31:0]        s1_c_r;
  logic               s1_byp_r;
  logic [31:0]        s1_bval_r;
  // stage 2: product normalized, addend offset
  logic [47:0]        s2_mpn_r;
  logic signed [11:0] s2_d_r;
  logic signed [11:0] s2_sah_r;
  logic               s2_sp_r;
  logic [31:0]        s2_c_r;
  logic               s2_byp_r;
  logic [31:0]        s2_bval_r;
  // stage 3: aligned sum magnitude
  logic [76:0]        s3_s_r;
  logic               s3_sg_r;
  logic               s3_zero_r;
  logic signed [11:0] s3_sah_r;
  logic               s3_byp_r;
  logic [31:0]        s3_bval_r;
  // stage 4: leading zeros
  logic [76:0]        s4_s_r;
  logic [6:0]         s4_lz_r;
  logic               s4_sg_r;
  logic               s4_zero_r;
  logic signed [11:0] s4_sah_r;
  logic               s4_byp_r;
  logic [31:0]        s4_bval_r;
  // stage 5: normalized or denormalized significand
  logic [76:0]        s5_t_r;
  logic               s5_lost_r;
  logic [9:0]         s5_ebase_r;
  logic               s5_sg_r;
  logic               s5_zero_r;
  logic               s5_byp_r;
  logic [31:0]        s5_bval_r;
  // stage 6: rounded result
  logic [31:0]        res_r;

  // Stage valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], start};
    end
  end

  assign done   = v_r[5];
  assign result = res_r;

  // Stage 1
  logic [7:0]  ea_f, eb_f, ec_f;
  logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
  logic        sp, prod_inf, prod_zero;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;
  logic        byp1;
  logic [31:0] bval1;

  always_comb begin
    ea_f   = op_a[30:23];
    eb_f   = op_b[30:23];
    ec_f   = op_c[30:23];
    a_nan  = (ea_f == 8'hFF) && (op_a[22:0] != 23'd0);
    b_nan  = (eb_f == 8'hFF) && (op_b[22:0] != 23'd0);
    c_nan  = (ec_f == 8'hFF) && (op_c[22:0] != 23'd0);
    a_inf  = (ea_f == 8'hFF) && (op_a[22:0] == 23'd0);
    b_inf  = (eb_f == 8'hFF) && (op_b[22:0] == 23'd0);
    c_inf  = (ec_f == 8'hFF) && (op_c[22:0] == 23'd0);
    a_zero = (op_a[30:0] == 31'd0);
    b_zero = (op_b[30:0] == 31'd0);
    c_zero = (op_c[30:0] == 31'd0);
    sp        = op_a[31] ^ op_b[31];
    prod_inf  = a_inf | b_inf;
    prod_zero = a_zero | b_zero;
    ma = {ea_f != 8'd0, op_a[22:0]};
    mb = {eb_f != 8'd0, op_b[22:0]};
    ea = (ea_f == 8'd0) ? 8'd1 : ea_f;
    eb = (eb_f == 8'd0) ? 8'd1 : eb_f;
    byp1  = 1'b1;
    bval1 = sqd_pkg::F32_QNAN;
    priority if (a_nan || b_nan || c_nan || (prod_inf && prod_zero) ||
                 (prod_inf && c_inf && (sp != op_c[31]))) begin
      bval1 = sqd_pkg::F32_QNAN;
    end else if (prod_inf) begin
      bval1 = {sp, 8'hFF, 23'd0};
    end else if (c_inf) begin
      bval1 = op_c;
    end else if (prod_zero) begin
      bval1 = c_zero ? {sp & op_c[31], 31'd0} : op_c;
    end else begin
      byp1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s1_mp_r   <= ma * mb;
    s1_eab_r  <= {2'b0, ea} + {2'b0, eb};
    s1_sp_r   <= sp;
    s1_c_r    <= op_c;
    s1_byp_r  <= byp1;
    s1_bval_r <= bval1;
  end

  // Stage 2: normalize product, offset of addend against product
  logic [5:0]         lzp;
  logic [7:0]         ec2;
  logic signed [11:0] d2, sah2;
  logic               c_nz2;

  always_comb begin
    lzp   = lzc48(s1_mp_r);
    ec2   = (s1_c_r[30:23] == 8'd0) ? 8'd1 : s1_c_r[30:23];
    c_nz2 = (s1_c_r[30:0] != 31'd0);
    d2    = 12'sd150 + $signed({4'b0, ec2}) - $signed({2'b0, s1_eab_r})
            + $signed({6'b0, lzp});
    sah2  = $signed({2'b0, s1_eab_r}) - $signed({6'b0, lzp}) - 12'sd101;
  end

  always_ff @(posedge clk) begin
    s2_mpn_r <= s1_mp_r << lzp;
    s2_d_r   <= d2;
    s2_sah_r <= sah2;
    s2_sp_r  <= s1_sp_r;
    s2_c_r   <= s1_c_r;
    // addend far above the product: product only nudges below half an ulp
    if (!s1_byp_r && c_nz2 && (d2 >= 12'sd50)) begin
      s2_byp_r  <= 1'b1;
      s2_bval_r <= s1_c_r;
    end else begin
      s2_byp_r  <= s1_byp_r;
      s2_bval_r <= s1_bval_r;
    end
  end

  // Stage 3: align addend, add or subtract, magnitude
  logic signed [11:0] posn, rsh;
  logic [23:0]        mc;
  logic [76:0]        cal, pw, s3;
  logic [77:0]        diff;
  logic               stk, sc, sg3;

  always_comb begin
    sc   = s2_c_r[31];
    mc   = {s2_c_r[30:23] != 8'd0, s2_c_r[22:0]};
    posn = s2_d_r + 12'sd3;
    rsh  = -posn;
    stk  = 1'b0;
    cal  = '0;
    if (s2_c_r[30:0] == 31'd0) begin
      cal = '0;
    end else if (!posn[11]) begin
      cal = {53'd0, mc} << posn[5:0];
    end else if (rsh >= 12'sd24) begin
      stk = |mc;
    end else begin
      cal = {53'd0, mc >> rsh[4:0]};
      stk = |(mc & ((24'd1 << rsh[4:0]) - 24'd1));
    end
    cal[0] = cal[0] | stk;
    pw   = {26'd0, s2_mpn_r, 3'd0};
    diff = {1'b0, pw} - {1'b0, cal};
    if (s2_sp_r == sc) begin
      s3  = pw + cal;
      sg3 = s2_sp_r;
    end else if (diff[77]) begin
      s3  = 77'(78'd0 - diff);
      sg3 = sc;
    end else begin
      s3  = diff[76:0];
      sg3 = s2_sp_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_s_r    <= s3;
    s3_sg_r   <= sg3;
    s3_zero_r <= (s3 == 77'd0);
    s3_sah_r  <= s2_sah_r;
    s3_byp_r  <= s2_byp_r;
    s3_bval_r <= s2_bval_r;
  end

  // Stage 4: leading zero count
  always_ff @(posedge clk) begin
    s4_s_r    <= s3_s_r;
    s4_lz_r   <= lzc77(s3_s_r);
    s4_sg_r   <= s3_sg_r;
    s4_zero_r <= s3_zero_r;
    s4_sah_r  <= s3_sah_r;
    s4_byp_r  <= s3_byp_r;
    s4_bval_r <= s3_bval_r;
  end

  // Stage 5: shift to normal form, or to the subnormal grid
  logic signed [11:0] lzs, nsah;
  logic [7:0]         r8;
  logic [76:0]        t5;
  logic               lost5;
  logic [9:0]         ebase5;

  always_comb begin
    lzs    = $signed({5'd0, s4_lz_r});
    nsah   = -s4_sah_r;
    r8     = nsah[7:0];
    lost5  = 1'b0;
    ebase5 = 10'd0;
    if (s4_sah_r >= lzs) begin
      t5     = s4_s_r << s4_lz_r;
      ebase5 = 10'(s4_sah_r - lzs);
    end else if (!s4_sah_r[11]) begin
      t5 = s4_s_r << s4_sah_r[6:0];
    end else begin
      t5    = s4_s_r >> r8;
      lost5 = |(s4_s_r & ((77'd1 << r8) - 77'd1));
    end
  end

  always_ff @(posedge clk) begin
    s5_t_r     <= t5;
    s5_lost_r  <= lost5;
    s5_ebase_r <= ebase5;
    s5_sg_r    <= s4_sg_r;
    s5_zero_r  <= s4_zero_r;
    s5_byp_r   <= s4_byp_r;
    s5_bval_r  <= s4_bval_r;
  end

  // Stage 6: round to nearest even and pack
  logic [23:0] mant;
  logic        grd, sticky, inc;
  logic [33:0] rv;
  logic [31:0] res_nxt;

  always_comb begin
    mant   = s5_t_r[76:53];
    grd    = s5_t_r[52];
    sticky = (|s5_t_r[51:0]) | s5_lost_r;
    inc    = grd & (sticky | mant[0]);
    rv     = {1'b0, s5_ebase_r, 23'd0} + {10'd0, mant} + {33'd0, inc};
    priority if (s5_byp_r) begin
      res_nxt = s5_bval_r;
    end else if (s5_zero_r) begin
      res_nxt = sqd_pkg::F32_POS_ZERO;
    end else if (rv >= EXP_OVF) begin
      res_nxt = {s5_sg_r, 8'hFF, 23'd0};
    end else begin
      res_nxt = {s5_sg_r, rv[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

### rtl/sqd_dp.sv
// Datapath: block header store, item capture, operand select, FMA, accumulator, output register
module sqd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sqd_pkg::cmd_t      cmd,
  output sqd_pkg::sts_t      sts,
  input  logic [15:0]        block_scale_half,
  input  logic [15:0]        block_min_half,
  input  logic [63:0]        packed_scales_low,
  input  logic [31:0]        packed_scales_high,
  input  logic [7:0]         quant_byte,
  input  logic [31:0]        act_for_low,
  input  logic [31:0]        act_for_high,
  input  logic               row_end,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        dot_value
);

  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [10:0] mm;
    logic [31:0] f;
    e  = h[14:10];
    m  = h[9:0];
    p  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mm = {1'b0, m} << (4'd10 - p);
    if (e == 5'd31) begin
      f = {h[15], 8'hFF, m, 13'd0};
    end else if (e == 5'd0) begin
      f = (m == 10'd0) ? {h[15], 31'd0}
                       : {h[15], 8'(8'd103 + {4'd0, p}), mm[9:0], 13'd0};
    end else begin
      f = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return f;
  endfunction

  function automatic logic [31:0] int_to_f32(input logic [5:0] n);
    logic [2:0]  p;
    logic [28:0] sh;
    logic [31:0] f;
    p = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (n[i]) p = 3'(i);
    end
    sh = {23'd0, n} << (5'd23 - {2'd0, p});
    f  = (n == 6'd0) ? 32'd0 : {1'b0, 8'(8'd127 + {5'd0, p}), sh[22:0]};
    return f;
  endfunction

  logic [31:0] scale_r, min_r, sum_r;
  logic [5:0]  subsc_r [8];
  logic [5:0]  submn_r [8];
  logic [6:0]  pos_r;
  logic [7:0]  q_r;
  logic [31:0] xl_r, xh_r;
  logic        row_end_r;
  logic [31:0] t_d1_r, t_m1_r, t_d2_r, t_m2_r, t_vl_r, t_vh_r;
  logic        out_valid_r;
  logic [31:0] dot_r;

  // Header: unpack the twelve scale bytes
  logic [7:0] sb [12];
  always_comb begin
    for (int i = 0; i < 8; i++) sb[i] = packed_scales_low[8*i +: 8];
    for (int i = 0; i < 4; i++) sb[8+i] = packed_scales_high[8*i +: 8];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      for (int i = 0; i < 4; i++) begin
        subsc_r[i]   <= sb[i][5:0];
        subsc_r[i+4] <= {sb[i][7:6], sb[i+8][3:0]};
        submn_r[i]   <= sb[i+4][5:0];
        submn_r[i+4] <= {sb[i+4][7:6], sb[i+8][7:4]};
      end
    end
  end

  // Data beat capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      q_r       <= quant_byte;
      xl_r      <= act_for_low;
      xh_r      <= act_for_high;
      row_end_r <= row_end;
    end
  end

  // Operand select for the current step
  logic [2:0]  idx_lo, idx_hi;
  logic [31:0] opa, opb, opc;
  always_comb begin
    idx_lo = {pos_r[6:5], 1'b0};
    idx_hi = {pos_r[6:5], 1'b1};
    unique case (cmd.op)
      sqd_pkg::OP_D1: begin
        opa = scale_r; opb = int_to_f32(subsc_r[idx_lo]); opc = sqd_pkg::F32_NEG_ZERO;
      end
      sqd_pkg::OP_M1: begin
        opa = min_r;   opb = int_to_f32(submn_r[idx_lo]); opc = sqd_pkg::F32_NEG_ZERO;
      end
      sqd_pkg::OP_D2: begin
        opa = scale_r; opb = int_to_f32(subsc_r[idx_hi]); opc = sqd_pkg::F32_NEG_ZERO;
      end
      sqd_pkg::OP_M2: begin
        opa = min_r;   opb = int_to_f32(submn_r[idx_hi]); opc = sqd_pkg::F32_NEG_ZERO;
      end
      sqd_pkg::OP_VL: begin
        opa = t_d1_r;  opb = int_to_f32({2'd0, q_r[3:0]}); opc = {~t_m1_r[31], t_m1_r[30:0]};
      end
      sqd_pkg::OP_VH: begin
        opa = t_d2_r;  opb = int_to_f32({2'd0, q_r[7:4]}); opc = {~t_m2_r[31], t_m2_r[30:0]};
      end
      sqd_pkg::OP_AL: begin
        opa = t_vl_r;  opb = xl_r; opc = sum_r;
      end
      sqd_pkg::OP_AH: begin
        opa = t_vh_r;  opb = xh_r; opc = sum_r;
      end
      default: begin
        opa = '0; opb = '0; opc = '0;
      end
    endcase
  end

  logic        fma_done;
  logic [31:0] fma_res;

  sqd_fma u_fma (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .op_a   (opa),
    .op_b   (opb),
    .op_c   (opc),
    .done   (fma_done),
    .result (fma_res)
  );

  // Step results into temporaries
  always_ff @(posedge clk) begin
    if (cmd.write_res) begin
      unique case (cmd.op)
        sqd_pkg::OP_D1: t_d1_r <= fma_res;
        sqd_pkg::OP_M1: t_m1_r <= fma_res;
        sqd_pkg::OP_D2: t_d2_r <= fma_res;
        sqd_pkg::OP_M2: t_m2_r <= fma_res;
        sqd_pkg::OP_VL: t_vl_r <= fma_res;
        sqd_pkg::OP_VH: t_vh_r <= fma_res;
        default: ;
      endcase
    end
  end

  // Block scales, position and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
      min_r   <= '0;
      pos_r   <= '0;
      sum_r   <= sqd_pkg::F32_POS_ZERO;
    end else begin
      if (cmd.load_hdr) begin
        scale_r <= half_to_f32(block_scale_half);
        min_r   <= half_to_f32(block_min_half);
        pos_r   <= '0;
      end
      if (cmd.write_res && (cmd.op == sqd_pkg::OP_AL || cmd.op == sqd_pkg::OP_AH)) begin
        sum_r <= fma_res;
      end
      if (cmd.write_res && cmd.op == sqd_pkg::OP_AH) begin
        pos_r <= row_end_r ? 7'd0 : 7'(pos_r + 7'd1);
      end
      if (cmd.emit) begin
        sum_r <= sqd_pkg::F32_POS_ZERO;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) dot_r <= sum_r;
  end

  assign out_valid    = out_valid_r;
  assign dot_value    = dot_r;
  assign sts.fma_done = fma_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.row_end  = row_end_r;

endmodule

### rtl/sqd_ctrl.sv
// Controller: accepts beats, steps the eight FMA passes of a data byte, emits at row end
module sqd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_ready,
  input  sqd_pkg::sts_t sts,
  output sqd_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t       state_r, state_nxt;
  sqd_pkg::op_t op_r, op_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = op_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == sqd_pkg::MODE_DATA) begin
            cmd.load_item = 1'b1;
            op_nxt        = sqd_pkg::OP_D1;
            state_nxt     = S_ISSUE;
          end else begin
            cmd.load_hdr = 1'b1;
          end
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.fma_done) begin
          cmd.write_res = 1'b1;
          if (op_r == sqd_pkg::OP_AH) begin
            state_nxt = sts.row_end ? S_EMIT : S_IDLE;
          end else begin
            op_nxt    = sqd_pkg::op_t'(3'(op_r + 3'd1));
            state_nxt = S_ISSUE;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= sqd_pkg::OP_D1;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule
